### hdl/shcred_pkg.sv
// shared types, codes and constants for the salted hash credential table
// no dependencies; imported by shcred_fnv_unit and salted_hash_credential_table
package shcred_pkg;

  localparam int BYTE_W     = 8;
  localparam int HASH_W     = 64;
  localparam int LEVEL_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int OUT_IDX_W  = 4;
  localparam int SALT_LEN   = 20;
  localparam int SALT_CNT_W = 5;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'd2166136261;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_BAD_PASS  = 2'd1;
  localparam status_t STAT_NOT_FOUND = 2'd2;
  localparam status_t STAT_FULL      = 2'd3;

  // salt rom, absorbed before the first password byte
  function automatic logic [BYTE_W-1:0] salt_byte(input logic [SALT_CNT_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      5'd0:    b = "c";
      5'd1:    b = "0";
      5'd2:    b = "u";
      5'd3:    b = "r";
      5'd4:    b = "s";
      5'd5:    b = "e";
      5'd6:    b = "W";
      5'd7:    b = "0";
      5'd8:    b = "r";
      5'd9:    b = "k";
      5'd10:   b = "_";
      5'd11:   b = "s";
      5'd12:   b = "a";
      5'd13:   b = "l";
      5'd14:   b = "t";
      5'd15:   b = "_";
      5'd16:   b = "2";
      5'd17:   b = "0";
      5'd18:   b = "2";
      5'd19:   b = "6";
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

### hdl/shcred_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module shcred_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/shcred_fnv_unit.sv
// shared fnv-1a step unit (32-bit fnv prime and basis) holding the running 64-bit hash
// depends on shcred_pkg
module shcred_fnv_unit
  import shcred_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_basis,
  input  logic              step_en,
  input  logic [BYTE_W-1:0] step_byte,
  output logic [HASH_W-1:0] hash
);

  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] product;

  // prime 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
  assign mixed   = hash_r ^ {{(HASH_W-BYTE_W){1'b0}}, step_byte};
  assign product = (mixed << 24) + (mixed << 8) + (mixed << 7)
                 + (mixed << 4) + (mixed << 1) + mixed;

  always_comb begin
    hash_nxt = hash_r;
    if (load_basis) begin
      hash_nxt = FNV_BASIS;
    end else if (step_en) begin
      hash_nxt = product;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

### hdl/salted_hash_credential_table.sv
// a name word on an empty table needs no scan, else it runs an entry scan; a password
// word is accepted, then hashed, and the first one first absorbs the salt through the
// shared fnv step unit; a final word registers the entry or runs the authenticate scan
// (none for an over-long name), then loads the output word; one word in flight at a time
// reset clears control, count and request state, hash goes to the fnv basis; entry
// memories are not cleared, only entries below entry_count are ever read
module salted_hash_credential_table
  import shcred_pkg::*;
#(
  parameter int MAX_ENTRIES     = 10,
  parameter int NAME_CAPACITY   = 32,
  parameter int SALTED_CAPACITY = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic                 in_segment,
  input  logic                 in_byte_valid,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_segment_end,
  input  logic [LEVEL_W-1:0]   in_user_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_IDX_W-1:0] out_entry_index,
  output logic [LEVEL_W-1:0]   out_entry_level
);

  // widths derived from the table geometry
  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int COL_W      = $clog2(NAME_CAPACITY);
  localparam int PASS_W     = $clog2(SALTED_CAPACITY);
  localparam int PASS_LIMIT = SALTED_CAPACITY - 1 - SALT_LEN;
  localparam int NAME_DEPTH = ((MAX_ENTRIES > 1) ? MAX_ENTRIES : 2) << COL_W;
  localparam int ENTRY_W    = COL_W + HASH_W + LEVEL_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NSCAN = 3'd1;
  localparam logic [2:0] ST_SALT  = 3'd2;
  localparam logic [2:0] ST_PWD   = 3'd3;
  localparam logic [2:0] ST_REG   = 3'd4;
  localparam logic [2:0] ST_RSCAN = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;          // entries registered
  logic [COL_W-1:0]       pos_r, pos_nxt;          // name bytes kept
  logic [MAX_ENTRIES-1:0] flags_r, flags_nxt;      // entries still matching the name
  logic                   too_long_r, too_long_nxt;
  logic                   inpw_r, inpw_nxt;        // salt absorbed, password phase
  logic [PASS_W-1:0]      pass_r, pass_nxt;        // password bytes absorbed
  logic [SALT_CNT_W-1:0]  salt_cnt_r, salt_cnt_nxt;
  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;

  // captured input word
  logic                   req_r;
  logic                   present_r;
  logic [BYTE_W-1:0]      byte_r;
  logic                   end_r;
  logic [LEVEL_W-1:0]     lvl_r;

  // output word register
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [OUT_IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [LEVEL_W-1:0]     out_lvl_r, out_lvl_nxt;
  // result held between the resolving state and the output load
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [OUT_IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [LEVEL_W-1:0]     res_lvl_r, res_lvl_nxt;

  logic                   accept;
  logic                   in_present;
  logic                   issue;
  logic                   room;

  // name memory, one row per entry
  logic                   name_we;
  logic [IDX_W+COL_W-1:0] name_waddr;
  logic [IDX_W+COL_W-1:0] name_raddr;
  logic [BYTE_W-1:0]      name_rd;

  // entry memory {length, hash, level}
  logic                   entry_we;
  logic [ENTRY_W-1:0]     entry_wdata;
  logic [ENTRY_W-1:0]     entry_rd;
  logic [COL_W-1:0]       rd_len;
  logic [HASH_W-1:0]      rd_hash;
  logic [LEVEL_W-1:0]     rd_lvl;

  // fnv unit control
  logic                   fnv_load;
  logic                   fnv_step;
  logic [BYTE_W-1:0]      fnv_byte;
  logic [HASH_W-1:0]      hash;

  logic [CNT_W+OUT_IDX_W-1:0] cnt_wide;
  logic [CNT_W+OUT_IDX_W-1:0] cmp_wide;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign in_present = in_byte_valid && (in_data_byte != '0);
  assign issue      = (scan_idx_r < cnt_r);
  assign room       = (cnt_r < CNT_W'(MAX_ENTRIES));
  assign cnt_wide   = {{OUT_IDX_W{1'b0}}, cnt_r};
  assign cmp_wide   = {{OUT_IDX_W{1'b0}}, cmp_idx_r};

  // a name byte lands in the row of the entry being built, at accept time
  assign name_we    = accept && !in_segment && !inpw_r && in_present && room
                      && (pos_r < COL_W'(NAME_CAPACITY - 1));
  assign name_waddr = {cnt_r[IDX_W-1:0], pos_r};
  assign name_raddr = {scan_idx_r[IDX_W-1:0], pos_r};

  assign entry_we    = (state_r == ST_REG) && room;
  assign entry_wdata = {pos_r, hash, lvl_r};
  assign {rd_len, rd_hash, rd_lvl} = entry_rd;

  shcred_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NAME_DEPTH)
  ) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (in_data_byte),
    .raddr (name_raddr),
    .rdata (name_rd)
  );

  shcred_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (entry_wdata),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (entry_rd)
  );

  shcred_fnv_unit u_fnv (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_basis (fnv_load),
    .step_en    (fnv_step),
    .step_byte  (fnv_byte),
    .hash       (hash)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    flags_nxt      = flags_r;
    too_long_nxt   = too_long_r;
    inpw_nxt       = inpw_r;
    pass_nxt       = pass_r;
    salt_cnt_nxt   = salt_cnt_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = scan_idx_r;
    cmp_vld_nxt    = 1'b0;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_lvl_nxt    = res_lvl_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_lvl_nxt    = out_lvl_r;
    fnv_load       = 1'b0;
    fnv_step       = 1'b0;
    fnv_byte       = byte_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_segment) begin
            // name word; ignored once the password phase has begun
            if (!inpw_r && in_present) begin
              if (pos_r >= COL_W'(NAME_CAPACITY - 1)) begin
                too_long_nxt = 1'b1;
              end else if (cnt_r == '0) begin
                pos_nxt = pos_r + 1'b1;
              end else begin
                scan_idx_nxt = '0;
                state_nxt    = ST_NSCAN;
              end
            end
          end else if (!inpw_r) begin
            salt_cnt_nxt = '0;
            state_nxt    = ST_SALT;
          end else begin
            state_nxt = ST_PWD;
          end
        end
      end

      ST_NSCAN: begin
        // drop entries whose name differs at this position
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          cmp_vld_nxt  = 1'b1;
        end
        if (cmp_vld_r && ((pos_r >= rd_len) || (name_rd != byte_r))) begin
          flags_nxt[cmp_idx_r[IDX_W-1:0]] = 1'b0;
        end
        if (!issue && !cmp_vld_r) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SALT: begin
        fnv_step = 1'b1;
        fnv_byte = salt_byte(salt_cnt_r);
        salt_cnt_nxt = salt_cnt_r + 1'b1;
        if (salt_cnt_r == SALT_CNT_W'(SALT_LEN - 1)) begin
          inpw_nxt  = 1'b1;
          pass_nxt  = '0;
          state_nxt = ST_PWD;
        end
      end

      ST_PWD: begin
        if (present_r && (pass_r < PASS_W'(PASS_LIMIT))) begin
          fnv_step = 1'b1;
          pass_nxt = pass_r + 1'b1;
        end
        if (!end_r) begin
          state_nxt = ST_IDLE;
        end else if (!req_r) begin
          state_nxt = ST_REG;
        end else if (too_long_r) begin
          res_status_nxt = STAT_NOT_FOUND;
          res_idx_nxt    = '0;
          res_lvl_nxt    = '0;
          state_nxt      = ST_EMIT;
        end else begin
          scan_idx_nxt = '0;
          state_nxt    = ST_RSCAN;
        end
      end

      ST_REG: begin
        if (room) begin
          res_status_nxt = STAT_OK;
          res_idx_nxt    = cnt_wide[OUT_IDX_W-1:0];
          res_lvl_nxt    = lvl_r;
          cnt_nxt        = cnt_r + 1'b1;
        end else begin
          res_status_nxt = STAT_FULL;
          res_idx_nxt    = '0;
          res_lvl_nxt    = '0;
        end
        state_nxt = ST_EMIT;
      end

      ST_RSCAN: begin
        // first surviving entry of equal length decides the outcome
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          cmp_vld_nxt  = 1'b1;
        end
        if (cmp_vld_r && flags_r[cmp_idx_r[IDX_W-1:0]] && (rd_len == pos_r)) begin
          if (rd_hash == hash) begin
            res_status_nxt = STAT_OK;
            res_idx_nxt    = cmp_wide[OUT_IDX_W-1:0];
            res_lvl_nxt    = rd_lvl;
          end else begin
            res_status_nxt = STAT_BAD_PASS;
            res_idx_nxt    = '0;
            res_lvl_nxt    = '0;
          end
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end else if (!issue && !cmp_vld_r) begin
          res_status_nxt = STAT_NOT_FOUND;
          res_idx_nxt    = '0;
          res_lvl_nxt    = '0;
          state_nxt      = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // load the output word once the slot is free, then clear request state
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_lvl_nxt    = res_lvl_r;
          fnv_load       = 1'b1;
          pos_nxt        = '0;
          flags_nxt      = '1;
          too_long_nxt   = 1'b0;
          inpw_nxt       = 1'b0;
          pass_nxt       = '0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      flags_r     <= '1;
      too_long_r  <= 1'b0;
      inpw_r      <= 1'b0;
      pass_r      <= '0;
      salt_cnt_r  <= '0;
      scan_idx_r  <= '0;
      cmp_idx_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      flags_r     <= flags_nxt;
      too_long_r  <= too_long_nxt;
      inpw_r      <= inpw_nxt;
      pass_r      <= pass_nxt;
      salt_cnt_r  <= salt_cnt_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_req_type;
      present_r <= in_present;
      byte_r    <= in_data_byte;
      end_r     <= in_segment_end;
      lvl_r     <= in_user_level;
    end
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_lvl_r    <= res_lvl_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_lvl_r    <= out_lvl_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;
  assign out_entry_level = out_lvl_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_name_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    name_we |-> room)
    else $error("name byte written into a full table");

  a_reg_increments: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REG) && room |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("registration did not advance entry count");

  a_pass_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !inpw_r |-> pass_r == '0)
    else $error("password count set outside password phase");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == ST_IDLE) && ($past(state_r) == ST_EMIT))
    else $error("result word loaded outside emit");
`endif

endmodule
